// ===== rtl/sdq_pkg.sv =====
// Shared types, constants and helpers for the stick direction quantizer.
package sdq_pkg;

  localparam int AXIS_BITS   = 16;
  localparam int THR_W       = 15;
  localparam int PREV_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = THR_W;

  // Threshold rescale from Q1.15 to the axis scale
  localparam int UP_SH       = (AXIS_BITS >= 16) ? AXIS_BITS - 16 : 0;
  localparam int DN_SH       = (AXIS_BITS >= 16) ? 0 : 16 - AXIS_BITS;
  localparam int SC_W        = THR_W + UP_SH;
  localparam int T_W         = AXIS_BITS - 1;

  localparam int MAG_W       = AXIS_BITS;
  localparam int SQ_W        = 2 * MAG_W - 1;
  localparam int TT_W        = 2 * T_W;
  localparam int SUM_W       = 2 * MAG_W;

  // tan(22.5 deg) ~= RATIO_NUM / 2^RATIO_SHIFT
  localparam int RATIO_W     = 15;
  localparam int RATIO_SHIFT = 16;
  localparam logic [RATIO_W-1:0] RATIO_NUM = 15'd27146;
  localparam int PROD_W      = MAG_W + RATIO_W;
  localparam int SH_W        = MAG_W + RATIO_SHIFT;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL   = 2'd2;

  localparam logic [THR_W-1:0] ACT_RESET = 15'd8192;
  localparam logic [THR_W-1:0] REL_RESET = 15'd6554;

  typedef enum logic [PREV_W-1:0] {
    DIR_NONE       = 4'd0,
    DIR_UP         = 4'd1,
    DIR_UP_RIGHT   = 4'd2,
    DIR_RIGHT      = 4'd3,
    DIR_DOWN_RIGHT = 4'd4,
    DIR_DOWN       = 4'd5,
    DIR_DOWN_LEFT  = 4'd6,
    DIR_LEFT       = 4'd7,
    DIR_UP_LEFT    = 4'd8
  } dir_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] axis_x;
    logic signed [AXIS_BITS-1:0] axis_y;
    logic [PREV_W-1:0]           prev_direction;
  } sample_t;

  typedef struct packed {
    logic ok;
    dir_t direction;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0] act_thr;
    logic [THR_W-1:0] rel_thr;
    logic             allow_diag;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic             xpos;
    logic             ypos;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [T_W-1:0]   thr;
  } mag_t;

  typedef struct packed {
    logic              ok;
    logic              xpos;
    logic              ypos;
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [TT_W-1:0]   sq_t;
    logic [PROD_W-1:0] rat_x;
    logic [PROD_W-1:0] rat_y;
  } prod_t;

  function automatic logic [T_W-1:0] scale_thr(input logic [THR_W-1:0] t);
    logic [SC_W-1:0] w;
    w = SC_W'(t) << UP_SH;
    return T_W'(w >> DN_SH);
  endfunction

endpackage

// ===== rtl/sdq_magnitude.sv =====
// First stage: axis magnitudes and signs, threshold pick, validity check.
module sdq_magnitude (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdq_pkg::sample_t in_beat,
  input  sdq_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output sdq_pkg::mag_t   out_beat
);
  import sdq_pkg::*;

  mag_t             stage_next;
  logic [MAG_W-1:0] x_u;
  logic [MAG_W-1:0] y_u;

  always_comb begin
    x_u = MAG_W'(in_beat.axis_x);
    y_u = MAG_W'(in_beat.axis_y);
    stage_next.ax   = x_u[MAG_W-1] ? (~x_u + 1'b1) : x_u;
    stage_next.ay   = y_u[MAG_W-1] ? (~y_u + 1'b1) : y_u;
    stage_next.xpos = !x_u[MAG_W-1] && (x_u != '0);
    stage_next.ypos = !y_u[MAG_W-1] && (y_u != '0);
    stage_next.ok   = (cfg.rel_thr <= cfg.act_thr) &&
                      (in_beat.prev_direction <= DIR_UP_LEFT);
    stage_next.thr  = (in_beat.prev_direction == DIR_NONE) ?
                      scale_thr(cfg.act_thr) : scale_thr(cfg.rel_thr);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_beat <= stage_next;
    end
  end

endmodule

// ===== rtl/sdq_square.sv =====
// Second stage: squares of the magnitudes and threshold, sector ratio products.
module sdq_square (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdq_pkg::mag_t in_beat,
  output logic          out_valid,
  input  logic          out_ready,
  output sdq_pkg::prod_t out_beat
);
  import sdq_pkg::*;

  prod_t stage_next;

  always_comb begin
    stage_next.ok    = in_beat.ok;
    stage_next.xpos  = in_beat.xpos;
    stage_next.ypos  = in_beat.ypos;
    stage_next.ax    = in_beat.ax;
    stage_next.ay    = in_beat.ay;
    stage_next.sq_x  = SQ_W'(in_beat.ax) * SQ_W'(in_beat.ax);
    stage_next.sq_y  = SQ_W'(in_beat.ay) * SQ_W'(in_beat.ay);
    stage_next.sq_t  = TT_W'(in_beat.thr) * TT_W'(in_beat.thr);
    stage_next.rat_x = PROD_W'(in_beat.ax) * PROD_W'(RATIO_NUM);
    stage_next.rat_y = PROD_W'(in_beat.ay) * PROD_W'(RATIO_NUM);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_beat <= stage_next;
    end
  end

endmodule

// ===== rtl/sdq_classify.sv =====
// Last stage: radius test and sector decision into the result register.
module sdq_classify (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdq_pkg::prod_t  in_beat,
  input  sdq_pkg::cfg_t   cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output sdq_pkg::result_t out_beat
);
  import sdq_pkg::*;

  result_t          stage_next;
  logic [SUM_W-1:0] radius_sq;
  logic             in_circle;
  logic             near_y;
  logic             near_x;

  always_comb begin
    radius_sq = SUM_W'(in_beat.sq_x) + SUM_W'(in_beat.sq_y);
    in_circle = radius_sq <= SUM_W'(in_beat.sq_t);
    // boundary samples go to the axis direction
    near_y    = {in_beat.ax, {RATIO_SHIFT{1'b0}}} <= SH_W'(in_beat.rat_y);
    near_x    = {in_beat.ay, {RATIO_SHIFT{1'b0}}} <= SH_W'(in_beat.rat_x);
    stage_next.ok = in_beat.ok;
    priority if (!in_beat.ok || in_circle) begin
      stage_next.direction = DIR_NONE;
    end else if (cfg.allow_diag) begin
      priority if (near_y) begin
        stage_next.direction = in_beat.ypos ? DIR_UP : DIR_DOWN;
      end else if (near_x) begin
        stage_next.direction = in_beat.xpos ? DIR_RIGHT : DIR_LEFT;
      end else if (in_beat.xpos) begin
        stage_next.direction = in_beat.ypos ? DIR_UP_RIGHT : DIR_DOWN_RIGHT;
      end else begin
        stage_next.direction = in_beat.ypos ? DIR_UP_LEFT : DIR_DOWN_LEFT;
      end
    end else if (in_beat.ax > in_beat.ay) begin
      stage_next.direction = in_beat.xpos ? DIR_RIGHT : DIR_LEFT;
    end else begin
      // Y wins ties
      stage_next.direction = in_beat.ypos ? DIR_UP : DIR_DOWN;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_beat <= stage_next;
    end
  end

endmodule

// ===== rtl/stick_direction_quantizer.sv =====
// Top level: config registers and the three-stage direction quantizer pipeline.
//
// Turns one signed two-axis stick sample plus the caller's previous direction
// into a direction code (0 none, 1..8 clockwise from up) and an ok flag. One
// beat is accepted per clock while in_ready is high and one result comes out
// per beat, in order, through the three register stages (magnitude,
// squares/products, classification into the output register). The only
// multipliers sit in the squares/products stage. in_ready is high whenever the
// output register is empty or being drained, and each stage holds its beat
// under backpressure, so stalls never drop or repeat a result. The block has
// no state of its own besides the three config registers; write them only
// while the pipeline is empty. Hysteresis comes from the caller feeding back
// the last direction: with prev none the activation radius applies, else the
// release radius. A radius exactly on the threshold counts as inside (none).
module stick_direction_quantizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sdq_pkg::sample_t                  in_beat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sdq_pkg::result_t                  out_beat,
  input  logic                              cfg_write,
  input  logic [sdq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sdq_pkg::*;

  cfg_t  cfg;
  logic  mag_valid;
  logic  mag_ready;
  mag_t  mag_beat;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_beat;

  // Config registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.act_thr    <= ACT_RESET;
      cfg.rel_thr    <= REL_RESET;
      cfg.allow_diag <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACTIVATION: cfg.act_thr    <= cfg_data[THR_W-1:0];
        REG_RELEASE:    cfg.rel_thr    <= cfg_data[THR_W-1:0];
        REG_DIAGONAL:   cfg.allow_diag <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: abs values, signs, threshold select, ok check
  sdq_magnitude u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .cfg       (cfg),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_beat  (mag_beat)
  );

  // Stage 2: x^2, y^2, t^2 and the tan(22.5) products
  sdq_square u_sq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mag_valid),
    .in_ready  (mag_ready),
    .in_beat   (mag_beat),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_beat  (prod_beat)
  );

  // Stage 3: compares and direction pick, output register
  sdq_classify u_cls (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_beat   (prod_beat),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

`ifndef SYNTHESIS
  // A failed check never carries a direction.
  a_bad_is_none: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.ok || out_beat.direction == DIR_NONE))
    else $error("ok=0 result carries a direction");

  // Codes above up-left never leave the block.
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.direction <= DIR_UP_LEFT))
    else $error("direction code out of range");

  // Four-way mode gives no diagonals.
  a_cardinal_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cfg.allow_diag) |->
      (out_beat.direction == DIR_NONE || out_beat.direction == DIR_UP ||
       out_beat.direction == DIR_RIGHT || out_beat.direction == DIR_DOWN ||
       out_beat.direction == DIR_LEFT))
    else $error("diagonal in four-way mode");

  // An empty output register means the whole pipe can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");
`endif

endmodule

// ===== verif/stick_direction_quantizer_tb.sv =====
// Self-checking testbench for the stick direction quantizer.
module stick_direction_quantizer_tb;
  import sdq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 34;
  localparam longint AXIS_MAX = (longint'(1) << (AXIS_BITS - 1)) - 1;
  localparam int THR_MAX      = (1 << THR_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               in_beat = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_beat;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ACTIVATION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the config registers, tracked on every write
  logic [THR_W-1:0] act_thr  = ACT_RESET;
  logic [THR_W-1:0] rel_thr  = REL_RESET;
  logic             diag_on  = 1'b1;

  result_t pending_dirs[$];
  result_t want;
  int      errors = 0;
  int      cycles = 0;
  bit      steady = 1'b0;   // no idling on either side while set

  stick_direction_quantizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Q1.15 threshold moved to the axis scale, truncating
  function automatic longint unsigned thr_to_axis(input logic [THR_W-1:0] thr);
    longint unsigned v;
    v = thr;
    if (AXIS_BITS >= 16) return v << (AXIS_BITS - 16);
    return v >> (16 - AXIS_BITS);
  endfunction

  function automatic longint unsigned axis_mag(input logic signed [AXIS_BITS-1:0] a);
    longint v;
    v = a;
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Expected direction for one sample under the current register copy
  function automatic result_t predict_direction(input sample_t s);
    longint unsigned ax, ay, t;
    bit              xpos, ypos;
    result_t         r;
    r.ok        = 1'b0;
    r.direction = DIR_NONE;
    if (rel_thr > act_thr || s.prev_direction > DIR_UP_LEFT) return r;
    ax   = axis_mag(s.axis_x);
    ay   = axis_mag(s.axis_y);
    xpos = !s.axis_x[AXIS_BITS-1] && (s.axis_x != 0);
    ypos = !s.axis_y[AXIS_BITS-1] && (s.axis_y != 0);
    t    = thr_to_axis((s.prev_direction == DIR_NONE) ? act_thr : rel_thr);
    r.ok = 1'b1;
    if (ax * ax + ay * ay <= t * t) begin
      r.direction = DIR_NONE;
    end else if (diag_on) begin
      // sector edges are inclusive toward the axes
      if ((ax << RATIO_SHIFT) <= ay * RATIO_NUM) begin
        r.direction = ypos ? DIR_UP : DIR_DOWN;
      end else if ((ay << RATIO_SHIFT) <= ax * RATIO_NUM) begin
        r.direction = xpos ? DIR_RIGHT : DIR_LEFT;
      end else if (xpos) begin
        r.direction = ypos ? DIR_UP_RIGHT : DIR_DOWN_RIGHT;
      end else begin
        r.direction = ypos ? DIR_UP_LEFT : DIR_DOWN_LEFT;
      end
    end else if (ax > ay) begin
      r.direction = xpos ? DIR_RIGHT : DIR_LEFT;
    end else begin
      // Y wins ties in cardinal mode
      r.direction = ypos ? DIR_UP : DIR_DOWN;
    end
    return r;
  endfunction

  // Magnitude plus sign to axis value; anything past full scale is the most negative code
  function automatic logic signed [AXIS_BITS-1:0] to_axis(input longint unsigned m,
                                                           input bit neg);
    if (m > AXIS_MAX) return {1'b1, {(AXIS_BITS-1){1'b0}}};
    return neg ? AXIS_BITS'(-longint'(m)) : AXIS_BITS'(longint'(m));
  endfunction

  // One beat on the input channel; valid stays up across back-to-back beats
  task automatic send_sample(input sample_t s);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= s;
    do @(posedge clk); while (!in_ready);
    pending_dirs.push_back(predict_direction(s));
  endtask

  task automatic send_xy(input longint x, input longint y, input logic [PREV_W-1:0] prev);
    sample_t s;
    s.axis_x         = AXIS_BITS'(x);
    s.axis_y         = AXIS_BITS'(y);
    s.prev_direction = prev;
    send_sample(s);
  endtask

  // Wait for every outstanding result; input side parked
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle; only called with the pipe empty
  task automatic set_config(input int act, input int rel, input bit diag);
    cfg_write <= 1'b1;
    cfg_index <= REG_ACTIVATION;
    cfg_data  <= CFG_DATA_W'(act);
    @(posedge clk);
    act_thr   = THR_W'(act);
    cfg_index <= REG_RELEASE;
    cfg_data  <= CFG_DATA_W'(rel);
    @(posedge clk);
    rel_thr   = THR_W'(rel);
    cfg_index <= REG_DIAGONAL;
    cfg_data  <= CFG_DATA_W'(diag);
    @(posedge clk);
    diag_on   = diag;
    cfg_write <= 1'b0;
  endtask

  // Random sample: mostly near the threshold circle or a sector edge
  task automatic send_random_sample();
    sample_t         s;
    int              pick;
    longint unsigned t, a, b, tmp;
    real             r;
    bit              nx, ny;
    pick = $urandom_range(0, 99);
    if (pick < 25) s.prev_direction = DIR_NONE;
    else if (pick < 88) s.prev_direction = PREV_W'($urandom_range(1, 8));
    else s.prev_direction = PREV_W'($urandom_range(9, 15));
    t  = thr_to_axis((s.prev_direction == DIR_NONE) ? act_thr : rel_thr);
    nx = $urandom_range(0, 1);
    ny = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    a = 0;
    b = 0;
    if (pick < 30) begin
      s.axis_x = AXIS_BITS'($urandom);
      s.axis_y = AXIS_BITS'($urandom);
    end else begin
      if (pick < 65) begin
        // just inside, on, or just outside the radius
        a = $urandom_range(0, int'(t));
        r = $sqrt(real'(t) * real'(t) - real'(a) * real'(a));
        b = longint'($floor(r)) + $urandom_range(0, 2);
        if (b != 0) b = b - 1;
      end else if (pick < 85) begin
        // around the tan(22.5 deg) edge
        b = $urandom_range(int'(t), int'(AXIS_MAX + 1));
        a = ((b * RATIO_NUM) >> RATIO_SHIFT) + $urandom_range(0, 2);
        if (a != 0) a = a - 1;
      end else begin
        case ($urandom_range(0, 3))
          0: a = 0;
          1: a = 1;
          2: a = AXIS_MAX;
          default: a = AXIS_MAX + 1;
        endcase
        case ($urandom_range(0, 3))
          0: b = 0;
          1: b = 1;
          2: b = AXIS_MAX;
          default: b = AXIS_MAX + 1;
        endcase
      end
      if ($urandom_range(0, 1)) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      s.axis_x = to_axis(a, nx);
      s.axis_y = to_axis(b, ny);
    end
    send_sample(s);
  endtask

  // Reset register values, threshold boundaries and hysteresis
  task automatic test_reset_defaults();
    send_xy(8192, 0, DIR_NONE);        // on the activation radius: none
    send_xy(8193, 0, DIR_NONE);
    send_xy(0, -8193, DIR_NONE);
    send_xy(6554, 0, DIR_RIGHT);       // on the release radius: none
    send_xy(6555, 0, DIR_RIGHT);       // held by hysteresis
    send_xy(-6555, 0, DIR_LEFT);
    send_xy(0, 0, DIR_NONE);
    drain();
  endtask

  // Full-scale corners, most negative axis, sector edges, zero axis
  task automatic test_extremes_and_sectors();
    set_config(0, 0, 1'b1);
    send_xy(AXIS_MAX, AXIS_MAX, DIR_NONE);
    send_xy(-AXIS_MAX - 1, -AXIS_MAX - 1, DIR_NONE);
    send_xy(-AXIS_MAX - 1, AXIS_MAX, DIR_UP);
    send_xy(AXIS_MAX, -AXIS_MAX - 1, DIR_UP);
    send_xy(13573, -AXIS_MAX - 1, DIR_NONE);   // exactly on the edge: down
    send_xy(13574, -AXIS_MAX - 1, DIR_NONE);
    send_xy(0, 0, DIR_NONE);                   // zero radius with zero threshold
    send_xy(0, 1, DIR_NONE);
    send_xy(-1, 0, DIR_NONE);
    send_xy(1, 0, DIR_NONE);
    send_xy(0, -1, DIR_NONE);
    drain();
  endtask

  task automatic test_cardinal_mode();
    set_config(100, 50, 1'b0);
    send_xy(20000, 20000, DIR_NONE);      // tie goes to Y
    send_xy(20000, -20000, DIR_DOWN);
    send_xy(20001, -20000, DIR_NONE);
    send_xy(-20001, 20000, DIR_LEFT);
    send_xy(-AXIS_MAX - 1, AXIS_MAX, DIR_NONE);
    drain();
  endtask

  // Release above activation, and previous codes past the last direction
  task automatic test_bad_config();
    set_config(100, 101, 1'b1);
    send_xy(20000, 0, DIR_NONE);
    drain();
    set_config(1000, 1000, 1'b1);
    send_xy(20000, 0, 4'd9);
    send_xy(-20000, 5, 4'd15);
    send_xy(0, 1001, DIR_UP_LEFT);
    drain();
  endtask

  // Random beats over a sweep of register settings
  task automatic test_random_phases();
    int act, rel, n;
    for (int phase = 0; phase < 9; phase++) begin
      n = 95;
      case (phase)
        0: set_config(ACT_RESET, REL_RESET, 1'b1);
        1: set_config(0, 0, 1'b1);
        2: begin
          set_config(THR_MAX, THR_MAX, 1'b0);
          steady = 1'b1;
        end
        3: set_config(THR_MAX, 0, 1'b1);
        5: begin
          act = $urandom_range(0, THR_MAX - 1);
          rel = $urandom_range(act + 1, THR_MAX);
          set_config(act, rel, $urandom_range(0, 1));
          n = 40;
        end
        default: begin
          act = $urandom_range(0, THR_MAX);
          rel = $urandom_range(0, act);
          set_config(act, rel, phase[0]);
        end
      endcase
      repeat (n) send_random_sample();
      drain();
      steady = 1'b0;
    end
  endtask

  // Output side: random stalls unless in a steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Result checker: in-order compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_dirs.size() == 0) begin
        $error("unexpected result beat: ok=%0d direction=%0d", out_beat.ok,
               out_beat.direction);
        errors++;
      end else begin
        want = pending_dirs.pop_front();
        if (out_beat.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, out_beat.ok);
          errors++;
        end
        if (out_beat.direction !== want.direction) begin
          $error("direction: expected %0d, actual %0d", want.direction,
                 out_beat.direction);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extremes_and_sectors();
    test_cardinal_mode();
    test_bad_config();
    test_random_phases();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_dirs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
